FILE: design/pofq_pkg.sv
// Package for the priority-or-FIFO queue: constants, codes and shared types.
`timescale 1ns / 1ps
package pofq_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int DATA_W_DEF  = 32;
  localparam int DATA_PORT_W = 32;
  localparam int PRIO_W      = 16;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 5;

  // Priority given to entries pushed in FIFO mode: the least urgent value.
  localparam logic signed [PRIO_W-1:0] PRIO_LOWEST = 16'sh7FFF;

  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_POP   = 1'b1;
  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_PRIO = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture a result for the accepted transaction
    logic push;   // insert the new entry
    logic pop;    // remove the head entry
  } pofq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
  } pofq_stat_t;

endpackage

FILE: design/pofq_if.sv
// Channel interfaces of the priority-or-FIFO queue: request and result.
`timescale 1ns / 1ps
interface pofq_in_if;
  import pofq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [DATA_PORT_W-1:0]   data_in;
  logic signed [PRIO_W-1:0] priority_in;

  modport source (output valid, output action, output data_in, output priority_in,
                  input ready);
  modport sink   (input valid, input action, input data_in, input priority_in,
                  output ready);
endinterface

interface pofq_out_if;
  import pofq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic                     popped_valid;
  logic [DATA_PORT_W-1:0]   popped_data;
  logic signed [PRIO_W-1:0] popped_priority;
  logic                     head_valid;
  logic [DATA_PORT_W-1:0]   head_data;
  logic signed [PRIO_W-1:0] head_priority;
  logic [COUNT_OUT_W-1:0]   entry_count;

  modport source (output valid, output status, output popped_valid, output popped_data,
                  output popped_priority, output head_valid, output head_data,
                  output head_priority, output entry_count, input ready);
  modport sink   (input valid, input status, input popped_valid, input popped_data,
                  input popped_priority, input head_valid, input head_data,
                  input head_priority, input entry_count, output ready);
endinterface

FILE: design/priority_or_fifo_queue.sv
// Top level of the priority-or-FIFO queue.
`timescale 1ns / 1ps
// A bounded queue of DEPTH entries held in a shift-register array kept in service
// order; every slot compares its priority with the new one in parallel, so a push
// or a pop needs no search. A transaction is taken every clock cycle as long as the
// result side keeps up: the result is registered and appears in the cycle after the
// request is accepted, and a new request is taken in the same cycle that the waiting
// result is collected. queue_mode selects FIFO order (0) or priority order (1, lower
// value first); the user must write it through cfg_we and cfg_wdata only while the
// queue is idle, which the block does not enforce. A write leaves the stored entries
// in place. No clearing pass follows reset; the queue starts empty and ready.
module priority_or_fifo_queue #(
  parameter int DEPTH  = pofq_pkg::DEPTH_DEF,
  parameter int DATA_W = pofq_pkg::DATA_W_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  pofq_in_if.sink    in_ch,
  pofq_out_if.source out_ch
);
  import pofq_pkg::*;

  pofq_cmd_t  cmd;
  pofq_stat_t stat;

  pofq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pofq_dp #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .cmd                 (cmd),
    .stat                (stat),
    .in_action           (in_ch.action),
    .in_data             (in_ch.data_in),
    .in_priority         (in_ch.priority_in),
    .res_status          (out_ch.status),
    .res_popped_valid    (out_ch.popped_valid),
    .res_popped_data     (out_ch.popped_data),
    .res_popped_priority (out_ch.popped_priority),
    .res_head_valid      (out_ch.head_valid),
    .res_head_data       (out_ch.head_data),
    .res_head_priority   (out_ch.head_priority),
    .res_entry_count     (out_ch.entry_count)
  );

endmodule

FILE: design/pofq_ctrl.sv
// Controller of the priority-or-FIFO queue: handshakes and command decode.
`timescale 1ns / 1ps
module pofq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_action,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  pofq_pkg::pofq_stat_t stat,
  output pofq_pkg::pofq_cmd_t  cmd
);
  import pofq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_HOLD = 2'b10
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;
  logic        accept;

  // The result register may be refilled in the cycle that its contents are taken.
  assign in_ready  = (state_r == ST_IDLE) || out_ready;
  assign out_valid = (state_r == ST_HOLD);
  assign accept    = in_valid && in_ready;

  assign cmd.load = accept;
  assign cmd.push = accept && (in_action == ACT_PUSH) && !stat.full;
  assign cmd.pop  = accept && (in_action == ACT_POP) && !stat.empty;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (!accept && out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/pofq_dp.sv
// Datapath of the priority-or-FIFO queue: sorted shift array and result register.
`timescale 1ns / 1ps
module pofq_dp #(
  parameter int DEPTH  = pofq_pkg::DEPTH_DEF,
  parameter int DATA_W = pofq_pkg::DATA_W_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic                                 cfg_wdata,
  input  pofq_pkg::pofq_cmd_t                  cmd,
  output pofq_pkg::pofq_stat_t                 stat,
  input  logic                                 in_action,
  input  logic [pofq_pkg::DATA_PORT_W-1:0]     in_data,
  input  logic signed [pofq_pkg::PRIO_W-1:0]   in_priority,
  output logic [pofq_pkg::STATUS_W-1:0]        res_status,
  output logic                                 res_popped_valid,
  output logic [pofq_pkg::DATA_PORT_W-1:0]     res_popped_data,
  output logic signed [pofq_pkg::PRIO_W-1:0]   res_popped_priority,
  output logic                                 res_head_valid,
  output logic [pofq_pkg::DATA_PORT_W-1:0]     res_head_data,
  output logic signed [pofq_pkg::PRIO_W-1:0]   res_head_priority,
  output logic [pofq_pkg::COUNT_OUT_W-1:0]     res_entry_count
);
  import pofq_pkg::*;

  localparam int SLOT_W = (DATA_W < DATA_PORT_W) ? DATA_W : DATA_PORT_W;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam logic [DEPTH-1:0] ONE_HOT0 = DEPTH'(1);

  logic [SLOT_W-1:0]        data_r [DEPTH];
  logic signed [PRIO_W-1:0] prio_r [DEPTH];
  logic [SLOT_W-1:0]        data_nxt [DEPTH];
  logic signed [PRIO_W-1:0] prio_nxt [DEPTH];
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     mode_r;

  logic [DEPTH-1:0]         lt;       // slot held and more urgent than the new entry
  logic [DEPTH-1:0]         ahead;    // slot lies ahead of the insertion point
  logic                     head_ins;
  logic [SLOT_W-1:0]        new_data;
  logic signed [PRIO_W-1:0] new_prio;
  status_t                  status_nxt;

  logic [STATUS_W-1:0]      status_r;
  logic                     pvalid_r, hvalid_r;
  logic [SLOT_W-1:0]        pdata_r, hdata_r;
  logic signed [PRIO_W-1:0] pprio_r, hprio_r;
  logic [CNT_W-1:0]         rcount_r;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);

  assign new_data = in_data[SLOT_W-1:0];
  assign new_prio = (mode_r == MODE_PRIO) ? in_priority : PRIO_LOWEST;
  assign head_ins = stat.empty || (prio_r[0] > in_priority);

  // Every slot decides in parallel whether it stays, takes the new entry or
  // takes its neighbour's entry; no search loop runs across the array.
  always_comb begin
    logic [DEPTH-1:0] mask;
    mask = '0;
    for (int i = 0; i < DEPTH; i++) begin
      lt[i] = (CNT_W'(i) < count_r) && (prio_r[i] < in_priority);
    end
    for (int i = 0; i < DEPTH; i++) begin
      mask = ((ONE_HOT0 << (i + 1)) - ONE_HOT0) & ~ONE_HOT0;
      if (mode_r == MODE_FIFO) begin
        ahead[i] = CNT_W'(i) < count_r;
      end else if (i == 0) begin
        ahead[i] = !head_ins;
      end else begin
        ahead[i] = !head_ins && ((~lt & mask) == '0);
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    for (int i = 0; i < DEPTH; i++) begin
      data_nxt[i] = data_r[i];
      prio_nxt[i] = prio_r[i];
      if (cmd.push) begin
        if (ahead[i]) begin
          data_nxt[i] = data_r[i];
        end else if (i == 0) begin
          data_nxt[i] = new_data;
          prio_nxt[i] = new_prio;
        end else if (ahead[i-1]) begin
          data_nxt[i] = new_data;
          prio_nxt[i] = new_prio;
        end else begin
          data_nxt[i] = data_r[i-1];
          prio_nxt[i] = prio_r[i-1];
        end
      end else if (cmd.pop && (i < DEPTH - 1)) begin
        data_nxt[i] = data_r[i+1];
        prio_nxt[i] = prio_r[i+1];
      end
    end
    if (cmd.push) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    status_nxt = STAT_DONE;
    if (!cmd.push && !cmd.pop) begin
      status_nxt = (in_action == ACT_POP) ? STAT_EMPTY : STAT_FULL;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      data_r[i] <= data_nxt[i];
      prio_r[i] <= prio_nxt[i];
    end
    if (cmd.load) begin
      status_r <= status_nxt;
      pvalid_r <= cmd.pop;
      pdata_r  <= cmd.pop ? data_r[0] : '0;
      pprio_r  <= cmd.pop ? prio_r[0] : '0;
      hvalid_r <= (count_nxt != '0);
      hdata_r  <= (count_nxt != '0) ? data_nxt[0] : '0;
      hprio_r  <= (count_nxt != '0) ? prio_nxt[0] : '0;
      rcount_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      mode_r  <= MODE_FIFO;
    end else begin
      count_r <= count_nxt;
      if (cfg_we) mode_r <= cfg_wdata;
    end
  end

  assign res_status          = status_r;
  assign res_popped_valid    = pvalid_r;
  assign res_popped_data     = DATA_PORT_W'(pdata_r);
  assign res_popped_priority = pprio_r;
  assign res_head_valid      = hvalid_r;
  assign res_head_data       = DATA_PORT_W'(hdata_r);
  assign res_head_priority   = hprio_r;
  assign res_entry_count     = COUNT_OUT_W'(rcount_r);

endmodule
